### rtl/led_strip_pattern_animator_unit_macros.svh
// Assertion macros shared by the LED strip pattern animator modules.
`ifndef LED_STRIP_PATTERN_ANIMATOR_UNIT_MACROS_SVH
`define LED_STRIP_PATTERN_ANIMATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lspa_pkg.sv
// Types and constants shared by the LED strip pattern animator modules.
`timescale 1ns / 1ps
package lspa_pkg;

  localparam int unsigned CNT_W = 6;
  localparam int unsigned IDX_W = 5;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  localparam logic [2:0] PAT_OFF       = 3'd0;
  localparam logic [2:0] PAT_FLOW      = 3'd1;
  localparam logic [2:0] PAT_FLOW_POST = 3'd2;
  localparam logic [2:0] PAT_GREEN     = 3'd3;
  localparam logic [2:0] PAT_RED       = 3'd4;
  localparam logic [2:0] PAT_FLASH     = 3'd5;

  localparam logic [31:0] FLOW_MS       = 32'd120;
  localparam logic [31:0] CHASE_MS      = 32'd80;
  localparam logic [31:0] FLASH_LIT_MS  = 32'd200;
  localparam logic [31:0] FLASH_DARK_MS = 32'd300;

  localparam logic [2:0] FLASH_LAST_PHASE = 3'd5;
  localparam logic [2:0] FLASH_END_PHASE  = 3'd6;

  localparam logic [7:0] FLOW_HEAD_LVL = 8'd80;
  localparam logic [7:0] FLOW_TAIL_LVL = 8'd20;
  localparam logic [7:0] CHASE_LVL     = 8'd60;
  localparam logic [7:0] FLASH_LVL     = 8'd80;

  localparam logic [CNT_W-1:0] PIXEL_COUNT_RST = 6'd8;

  typedef enum logic [2:0] {
    FRM_DARK,
    FRM_FLOW,
    FRM_GREEN,
    FRM_RED,
    FRM_FLASH
  } frame_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_TAIL
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic push;
    logic tail_start;
  } lspa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fire;
    logic last_pix;
    logic extra;
    logic slot_free;
  } lspa_sts_t;

endpackage

### rtl/lspa_ctrl.sv
// Sequencing state machine of the LED strip pattern animator.
`timescale 1ns / 1ps
`include "led_strip_pattern_animator_unit_macros.svh"
module lspa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output lspa_pkg::lspa_cmd_t cmd_o,
  input  lspa_pkg::lspa_sts_t sts_i
);

  lspa_pkg::ctl_state_e state_q, state_d;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lspa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.load       = 1'b0;
    cmd_o.push       = 1'b0;
    cmd_o.tail_start = 1'b0;
    unique case (state_q)
      lspa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.fire) begin
            state_d = lspa_pkg::ST_FRAME;
          end
        end
      end
      lspa_pkg::ST_FRAME: begin
        cmd_o.push = sts_i.slot_free;
        if (sts_i.slot_free && sts_i.last_pix) begin
          if (sts_i.extra) begin
            // The flash has finished: follow with a second dark frame.
            cmd_o.tail_start = 1'b1;
            state_d          = lspa_pkg::ST_TAIL;
          end else begin
            state_d = lspa_pkg::ST_IDLE;
          end
        end
      end
      lspa_pkg::ST_TAIL: begin
        cmd_o.push = sts_i.slot_free;
        if (sts_i.slot_free && sts_i.last_pix) begin
          state_d = lspa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lspa_pkg::ST_IDLE;
      end
    endcase
  end

  `LSPA_ASSERT_NEXT(a_quiet_item_stays_idle, accept && !sts_i.fire, state_q == lspa_pkg::ST_IDLE, "item without output left idle state")
  `LSPA_ASSERT_NEXT(a_flash_end_goes_tail, state_q == lspa_pkg::ST_FRAME && sts_i.slot_free && sts_i.last_pix && sts_i.extra, state_q == lspa_pkg::ST_TAIL, "second dark frame not started")
  `LSPA_ASSERT_NEXT(a_idle_holds, state_q == lspa_pkg::ST_IDLE && !in_valid_i, state_q == lspa_pkg::ST_IDLE, "left idle without a transaction")

endmodule

### rtl/lspa_datapath.sv
// Pattern state, frame decision, pixel counter and output register.
`timescale 1ns / 1ps
`include "led_strip_pattern_animator_unit_macros.svh"
module lspa_datapath #(
  parameter int unsigned MAX_PIXELS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_wdata_i,
  input  logic                opcode_i,
  input  logic [31:0]         now_ms_i,
  input  logic [2:0]          pattern_i,
  input  lspa_pkg::lspa_cmd_t cmd_i,
  output lspa_pkg::lspa_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [4:0]          pixel_index_o,
  output logic [7:0]          green_o,
  output logic [7:0]          red_o,
  output logic [7:0]          blue_o,
  output logic                last_pixel_o
);

  localparam logic [lspa_pkg::CNT_W-1:0] MaxCnt = lspa_pkg::CNT_W'(MAX_PIXELS);

  logic [lspa_pkg::CNT_W-1:0] pixel_count_q;
  logic [2:0]                 active_q;
  logic [lspa_pkg::IDX_W-1:0] step_q;
  logic [2:0]                 phase_q;
  logic [31:0]                last_q;
  logic                       done_q;

  lspa_pkg::frame_e           kind_q;
  logic [lspa_pkg::IDX_W-1:0] head_q;
  logic [lspa_pkg::CNT_W-1:0] tail_q;
  logic                       extra_q;
  logic [lspa_pkg::IDX_W-1:0] pix_q;

  logic                       out_valid_q;
  logic [4:0]                 out_idx_q;
  logic [7:0]                 out_g_q, out_r_q, out_b_q;
  logic                       out_last_q;

  logic [lspa_pkg::CNT_W-1:0] cnt;
  logic [31:0]                elapsed;
  logic [31:0]                interval;
  logic                       due;
  logic                       emits;
  lspa_pkg::frame_e           kind_d;
  logic                       flash_on;
  logic [lspa_pkg::CNT_W-1:0] step_inc;
  logic [lspa_pkg::IDX_W-1:0] step_adv;
  logic [lspa_pkg::CNT_W-1:0] tail_d;
  logic                       last_pix;
  logic [7:0]                 pg, pr, pb;

  assign cnt      = (pixel_count_q > MaxCnt) ? MaxCnt : pixel_count_q;
  assign elapsed  = now_ms_i - last_q;
  assign flash_on = !phase_q[0];

  always_comb begin
    case (active_q) inside
      lspa_pkg::PAT_GREEN, lspa_pkg::PAT_RED: interval = lspa_pkg::CHASE_MS;
      lspa_pkg::PAT_FLASH: interval = flash_on ? lspa_pkg::FLASH_LIT_MS : lspa_pkg::FLASH_DARK_MS;
      default: interval = lspa_pkg::FLOW_MS;
    endcase
  end

  // A last time of zero means the pattern has not fired yet.
  assign due = (last_q == 32'd0) || (elapsed >= interval);

  always_comb begin
    emits  = 1'b0;
    kind_d = lspa_pkg::FRM_DARK;
    if (opcode_i == lspa_pkg::OP_SELECT) begin
      emits = (pattern_i <= lspa_pkg::PAT_FLASH) && (pattern_i != active_q);
    end else begin
      case (active_q) inside
        lspa_pkg::PAT_FLOW, lspa_pkg::PAT_FLOW_POST: begin
          emits  = due;
          kind_d = lspa_pkg::FRM_FLOW;
        end
        lspa_pkg::PAT_GREEN: begin
          emits  = due;
          kind_d = lspa_pkg::FRM_GREEN;
        end
        lspa_pkg::PAT_RED: begin
          emits  = due;
          kind_d = lspa_pkg::FRM_RED;
        end
        lspa_pkg::PAT_FLASH: begin
          emits  = due && !done_q;
          kind_d = flash_on ? lspa_pkg::FRM_FLASH : lspa_pkg::FRM_DARK;
        end
        default: begin
          emits = 1'b0;
        end
      endcase
    end
  end

  assign step_inc = {1'b0, step_q} + 6'd1;
  assign step_adv = (step_inc >= cnt) ? '0 : step_inc[lspa_pkg::IDX_W-1:0];
  assign tail_d   = (step_q == '0) ? (cnt - 6'd1) : ({1'b0, step_q} - 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= lspa_pkg::PIXEL_COUNT_RST;
      active_q      <= lspa_pkg::PAT_OFF;
      step_q        <= '0;
      phase_q       <= '0;
      last_q        <= '0;
      done_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pixel_count_q <= cfg_wdata_i;
      end
      if (cmd_i.load && emits) begin
        if (opcode_i == lspa_pkg::OP_SELECT) begin
          active_q <= pattern_i;
          step_q   <= '0;
          phase_q  <= '0;
          last_q   <= '0;
          done_q   <= 1'b0;
        end else begin
          last_q <= now_ms_i;
          if (active_q == lspa_pkg::PAT_FLASH) begin
            phase_q <= phase_q + 3'd1;
            if (phase_q >= lspa_pkg::FLASH_LAST_PHASE) begin
              done_q <= 1'b1;
            end
          end else begin
            step_q <= step_adv;
          end
        end
      end
    end
  end

  // Frame description, latched when the transaction is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_d;
      head_q  <= step_q;
      tail_q  <= tail_d;
      extra_q <= (opcode_i == lspa_pkg::OP_TICK) && (active_q == lspa_pkg::PAT_FLASH)
                 && (phase_q >= lspa_pkg::FLASH_LAST_PHASE);
      pix_q   <= '0;
    end else if (cmd_i.tail_start) begin
      kind_q <= lspa_pkg::FRM_DARK;
      pix_q  <= '0;
    end else if (cmd_i.push) begin
      pix_q <= pix_q + 5'd1;
    end
  end

  assign last_pix = ({1'b0, pix_q} + 6'd1) == cnt;

  always_comb begin
    pg = '0;
    pr = '0;
    pb = '0;
    case (kind_q)
      lspa_pkg::FRM_FLOW: begin
        // The tail is drawn after the head and wins on a one-pixel strip.
        if ({1'b0, pix_q} == tail_q) begin
          pb = lspa_pkg::FLOW_TAIL_LVL;
        end else if (pix_q == head_q) begin
          pb = lspa_pkg::FLOW_HEAD_LVL;
        end
      end
      lspa_pkg::FRM_GREEN: pg = (pix_q == head_q) ? lspa_pkg::CHASE_LVL : 8'd0;
      lspa_pkg::FRM_RED:   pr = (pix_q == head_q) ? lspa_pkg::CHASE_LVL : 8'd0;
      lspa_pkg::FRM_FLASH: pr = lspa_pkg::FLASH_LVL;
      default: begin
        pg = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_idx_q  <= pix_q;
      out_g_q    <= pg;
      out_r_q    <= pr;
      out_b_q    <= pb;
      out_last_q <= last_pix;
    end
  end

  assign sts_o.fire      = emits && (cnt != '0);
  assign sts_o.last_pix  = last_pix;
  assign sts_o.extra     = extra_q;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign green_o       = out_g_q;
  assign red_o         = out_r_q;
  assign blue_o        = out_b_q;
  assign last_pixel_o  = out_last_q;

  `LSPA_ASSERT_NOW(a_done_at_end_phase, done_q, phase_q == lspa_pkg::FLASH_END_PHASE, "flash done before its last phase")
  `LSPA_ASSERT_NOW(a_done_only_flash, done_q, active_q == lspa_pkg::PAT_FLASH, "flash done mark outside the flash pattern")
  `LSPA_ASSERT_NOW(a_phase_bounded, 1'b1, phase_q <= lspa_pkg::FLASH_END_PHASE, "flash phase past its end")

endmodule

### rtl/led_strip_pattern_animator_unit.sv
// Top level of the LED strip pattern animator.
//
//   Channel   Handshake                 Carries
//   in        in_valid_i / in_ready_o   opcode_i, now_ms_i, pattern_i
//   out       out_valid_o / out_ready_i pixel_index_o, green_o, red_o, blue_o, last_pixel_o
//   cfg       cfg_we_i                  cfg_wdata_i (pixel count)
//
// An input transaction is taken in the idle state; a firing then sends one pixel per cycle
// while the output register has room: N pixels for a frame of N, or 2N at the end of the flash.
// The pixel counter in the datapath counts these pixels; the next item is taken once it is done.
// Reset brings back the off pattern, a pixel count of 8 and an empty output register.
// A stall on the output holds the pixel counter; the output register refills as it drains.
`timescale 1ns / 1ps
module led_strip_pattern_animator_unit #(
  parameter int unsigned MAX_PIXELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic [2:0]  pattern_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  pixel_index_o,
  output logic [7:0]  green_o,
  output logic [7:0]  red_o,
  output logic [7:0]  blue_o,
  output logic        last_pixel_o
);

  lspa_pkg::lspa_cmd_t cmd;
  lspa_pkg::lspa_sts_t sts;

  lspa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lspa_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .now_ms_i      (now_ms_i),
    .pattern_i     (pattern_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_o (pixel_index_o),
    .green_o       (green_o),
    .red_o         (red_o),
    .blue_o        (blue_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

### verif/led_strip_pattern_animator_unit_checker.sv
// Checker for the LED strip pattern animator: predicts each frame and compares every pixel.
`timescale 1ns / 1ps
module led_strip_pattern_animator_unit_checker
  import lspa_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic [2:0]  pattern_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [4:0]  pixel_index_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  blue_i,
  input  logic        last_pixel_i,
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned commands_o,
  output int unsigned pixels_o
);

  typedef struct packed {
    logic [4:0] idx;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
    logic       last;
  } pixel_t;

  pixel_t pixel_q[$];

  // Shadow of the block's animation state.
  logic [5:0]  strip_len;
  logic [2:0]  active_pat;
  logic [4:0]  step_pos;
  logic [2:0]  flash_ph;
  logic [31:0] last_fire_ms;
  logic        flash_over;

  logic [7:0] fr_g[MAX_PIXELS];
  logic [7:0] fr_r[MAX_PIXELS];
  logic [7:0] fr_b[MAX_PIXELS];

  function automatic int unsigned lit_len();
    return (strip_len > MAX_PIXELS) ? MAX_PIXELS : int'(strip_len);
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < MAX_PIXELS; i++) begin
      fr_g[i] = '0;
      fr_r[i] = '0;
      fr_b[i] = '0;
    end
  endtask

  task automatic put_pixel(input int unsigned pos, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    if (pos < lit_len()) begin
      fr_g[pos] = g;
      fr_r[pos] = r;
      fr_b[pos] = b;
    end
  endtask

  task automatic push_frame();
    int unsigned cnt;
    pixel_t px;
    cnt = lit_len();
    for (int unsigned i = 0; i < cnt; i++) begin
      px.idx  = i[4:0];
      px.g    = fr_g[i];
      px.r    = fr_r[i];
      px.b    = fr_b[i];
      px.last = (i + 1 == cnt);
      pixel_q.push_back(px);
    end
  endtask

  // A stored time of zero means the pattern has never fired, so it fires at once.
  function automatic bit fire_due(input logic [31:0] now, input logic [31:0] ivl);
    if (last_fire_ms != '0 && (now - last_fire_ms) < ivl) return 1'b0;
    last_fire_ms = now;
    return 1'b1;
  endfunction

  task automatic advance_step();
    int unsigned nxt;
    nxt = step_pos + 1;
    if (nxt >= lit_len()) nxt = 0;
    step_pos = nxt[4:0];
  endtask

  task automatic predict_frames(input logic op, input logic [31:0] now, input logic [2:0] pat);
    logic [7:0] tail;
    logic       lit;
    if (op == OP_SELECT) begin
      if (pat <= PAT_FLASH && pat != active_pat) begin
        clear_frame();
        push_frame();
        active_pat   = pat;
        step_pos     = '0;
        flash_ph     = '0;
        last_fire_ms = '0;
        flash_over   = 1'b0;
      end
    end else begin
      case (active_pat) inside
        PAT_FLOW, PAT_FLOW_POST: begin
          if (fire_due(now, FLOW_MS)) begin
            clear_frame();
            put_pixel(step_pos, 8'd0, 8'd0, FLOW_HEAD_LVL);
            // With an empty strip the tail wraps to 255 and so lands nowhere.
            tail = (step_pos == '0) ? 8'(lit_len() - 1) : 8'(step_pos - 1);
            put_pixel(tail, 8'd0, 8'd0, FLOW_TAIL_LVL);
            push_frame();
            advance_step();
          end
        end
        PAT_GREEN, PAT_RED: begin
          if (fire_due(now, CHASE_MS)) begin
            clear_frame();
            if (active_pat == PAT_GREEN) put_pixel(step_pos, 8'd0, CHASE_LVL, 8'd0);
            else put_pixel(step_pos, CHASE_LVL, 8'd0, 8'd0);
            push_frame();
            advance_step();
          end
        end
        PAT_FLASH: begin
          if (!flash_over) begin
            lit = ~flash_ph[0];
            if (fire_due(now, lit ? FLASH_LIT_MS : FLASH_DARK_MS)) begin
              clear_frame();
              if (lit) begin
                for (int unsigned i = 0; i < lit_len(); i++) put_pixel(i, FLASH_LVL, 8'd0, 8'd0);
              end
              push_frame();
              flash_ph = flash_ph + 3'd1;
              if (flash_ph >= FLASH_END_PHASE) begin
                flash_over = 1'b1;
                clear_frame();
                push_frame();
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic note_error(input pixel_t exp, input pixel_t got, input bit orphan);
    err_count_o++;
    if (err_count_o <= 10) begin
      if (orphan)
        $display("[%0t] unexpected pixel: idx=%0d g=%0d r=%0d b=%0d last=%0b", $realtime,
                 got.idx, got.g, got.r, got.b, got.last);
      else
        $display("[%0t] pixel mismatch: expected idx=%0d g=%0d r=%0d b=%0d last=%0b, got idx=%0d g=%0d r=%0d b=%0d last=%0b",
                 $realtime, exp.idx, exp.g, exp.r, exp.b, exp.last,
                 got.idx, got.g, got.r, got.b, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got;
    pixel_t exp;
    if (!rst_ni) begin
      pixel_q.delete();
      strip_len    = PIXEL_COUNT_RST;
      active_pat   = PAT_OFF;
      step_pos     = '0;
      flash_ph     = '0;
      last_fire_ms = '0;
      flash_over   = 1'b0;
      clear_frame();
      err_count_o  = 0;
      pending_o    = 0;
      commands_o   = 0;
      pixels_o     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{pixel_index_i, green_i, red_i, blue_i, last_pixel_i};
        pixels_o++;
        if (pixel_q.size() == 0) begin
          note_error(got, got, 1'b1);
        end else begin
          exp = pixel_q.pop_front();
          if (got !== exp) note_error(exp, got, 1'b0);
        end
      end
      if (cfg_we_i) strip_len = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        commands_o++;
        predict_frames(opcode_i, now_ms_i, pattern_i);
      end
      pending_o = pixel_q.size();
    end
  end

endmodule

### verif/led_strip_pattern_animator_unit_tb.sv
// Testbench top for the LED strip pattern animator: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module led_strip_pattern_animator_unit_tb;
  import lspa_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [31:0] now_ms_i;
  logic [2:0]  pattern_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  pixel_index_o;
  logic [7:0]  green_o;
  logic [7:0]  red_o;
  logic [7:0]  blue_o;
  logic        last_pixel_o;

  int unsigned err_count;
  int unsigned pending;
  int unsigned commands;
  int unsigned pixels;

  int unsigned burst_left;
  logic [31:0] cur_ms;
  int unsigned stall_mode;
  int unsigned stall_left;
  int unsigned slow_cnt;

  led_strip_pattern_animator_unit #(.MAX_PIXELS(32)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .now_ms_i      (now_ms_i),
    .pattern_i     (pattern_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_o (pixel_index_o),
    .green_o       (green_o),
    .red_o         (red_o),
    .blue_o        (blue_o),
    .last_pixel_o  (last_pixel_o)
  );

  led_strip_pattern_animator_unit_checker #(.MAX_PIXELS(32)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .opcode_i      (opcode_i),
    .now_ms_i      (now_ms_i),
    .pattern_i     (pattern_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_i (pixel_index_o),
    .green_i       (green_o),
    .red_i         (red_o),
    .blue_i        (blue_o),
    .last_pixel_i  (last_pixel_o),
    .err_count_o   (err_count),
    .pending_o     (pending),
    .commands_o    (commands),
    .pixels_o      (pixels)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The receiver switches between always ready, random stalls and a slow fixed rhythm.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 400);
    end
    stall_left--;
    slow_cnt++;
    case (stall_mode)
      0:       out_ready_i = 1'b1;
      1:       out_ready_i = 1'($urandom_range(0, 1));
      default: out_ready_i = (slow_cnt % 4 == 0);
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic drive_command(input logic op, input logic [31:0] now, input logic [2:0] pat);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i = 1'b1;
    opcode_i   = op;
    now_ms_i   = now;
    pattern_i  = pat;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drive_tick(input logic [31:0] now);
    drive_command(OP_TICK, now, 3'($urandom_range(0, 7)));
  endtask

  task automatic drive_select(input logic [2:0] pat);
    drive_command(OP_SELECT, $urandom, pat);
  endtask

  // Waits until every predicted pixel has arrived, then lets a command with no frame finish.
  task automatic drain_strip();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_pixel_count(input logic [5:0] len);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = len;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Mostly ticks spaced around the pattern intervals, with some selects and some noise.
  task automatic random_command();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      drive_select(($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5)));
    end else begin
      if (pick < 20) cur_ms = $urandom;
      else if (pick < 24) cur_ms = '0;
      else if (pick < 34) cur_ms = cur_ms + $urandom_range(0, 70);
      else cur_ms = cur_ms + $urandom_range(75, 320);
      drive_tick(cur_ms);
    end
  endtask

  initial begin
    logic [5:0] lens[8];
    int unsigned guard;
    lens = '{6'd63, 6'd1, 6'd0, 6'd32, 6'd20, 6'd3, 6'd13, 6'd8};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_TICK;
    now_ms_i    = '0;
    pattern_i   = PAT_OFF;
    burst_left  = 0;
    cur_ms      = 32'd20000;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at the reset length of eight pixels.
    drive_tick(32'd100);
    drive_select(3'd7);
    drive_select(3'd6);
    drive_select(PAT_FLOW);
    drive_select(PAT_FLOW);
    drive_tick(32'd0);
    drive_tick(32'd0);
    drive_tick(32'd50);
    drive_tick(32'd100);
    drive_tick(32'd170);
    drive_select(PAT_FLOW_POST);
    drive_tick(32'd1000);
    drive_tick(32'd1120);
    drive_select(PAT_GREEN);
    drive_tick(32'd5);
    drive_tick(32'd84);
    drive_tick(32'd85);
    drive_select(PAT_RED);
    drive_tick(32'hFFFF_FFF0);
    drive_tick(32'h0000_0040);
    drive_select(PAT_FLASH);
    foreach (lens[k]) begin
      if (k < 6) drive_tick(32'd10 + 32'd250 * k);
    end
    drive_tick(32'd5000);
    drive_select(PAT_OFF);

    for (int ph = 0; ph < 8; ph++) begin
      drain_strip();
      write_pixel_count(lens[ph]);
      for (int k = 0; k < 38; k++) random_command();
      // Walk the flow head well along so that the next, shorter strip starts past its end.
      if (lens[ph] == 6'd20) begin
        drive_select(PAT_FLOW);
        repeat (15) begin
          cur_ms = cur_ms + $urandom_range(120, 150);
          drive_tick(cur_ms);
        end
      end
    end

    in_valid_i = 1'b0;
    guard = 0;
    while (pending != 0 && guard < 500000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (80) @(negedge clk_i);
    $display("Run covered %0d input transactions and %0d pixels across eight strip lengths,",
             commands, pixels);
    $display("from an empty strip to an over-range count, with every pattern and the flash end.");
    if (err_count == 0 && pending == 0) begin
      $display("led_strip_pattern_animator_unit_tb: done, clean");
    end else begin
      $display("led_strip_pattern_animator_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d pixels still expected.", pending);
    $display("led_strip_pattern_animator_unit_tb: done, errors");
    $finish;
  end

endmodule
